[src/accumulator_vm_core_assert.svh]
// Assertion macros for the accumulator machine core.
`ifndef ACCUMULATOR_VM_CORE_ASSERT_SVH
`define ACCUMULATOR_VM_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define AVM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define AVM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AVM_ASSERT(name, clk, rst_n, prop, msg)
`define AVM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/avm_pkg.sv]
// Shared types and constants of the accumulator machine core.
`default_nettype none

package avm_pkg;

  localparam int unsigned ADDR_W = 8;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  localparam logic [DATA_W-1:0] PROGRAM_BASE = 16'd16;
  localparam logic [DATA_W-1:0] HALT_IP      = 16'd1000;
  localparam logic [DATA_W-1:0] SP_RESET     = 16'h00DF;

  // Memory-mapped ports and special registers
  localparam logic [ADDR_W-1:0] PORT_NUM  = 8'hE0;
  localparam logic [ADDR_W-1:0] PORT_CHR  = 8'hE1;
  localparam logic [ADDR_W-1:0] PORT_RND  = 8'hE2;
  localparam logic [ADDR_W-1:0] REG_STACK = 8'h0E;
  localparam logic [ADDR_W-1:0] REG_LINK  = 8'h0F;

  // Instruction prefixes
  localparam logic [7:0] PFX_HALT = 8'd0;
  localparam logic [7:0] PFX_LD   = 8'd4;
  localparam logic [7:0] PFX_ST   = 8'd5;
  localparam logic [7:0] PFX_LDI  = 8'd6;
  localparam logic [7:0] PFX_STI  = 8'd7;
  localparam logic [7:0] PFX_JZ   = 8'd8;
  localparam logic [7:0] PFX_JN   = 8'd9;
  localparam logic [7:0] PFX_JAL  = 8'd10;
  localparam logic [7:0] PFX_JI   = 8'd11;
  localparam logic [7:0] PFX_ALU  = 8'd12;
  localparam logic [7:0] PFX_SET  = 8'd13;

  // ALU subops
  localparam logic [3:0] SUB_ADD  = 4'd0;
  localparam logic [3:0] SUB_SUB  = 4'd1;
  localparam logic [3:0] SUB_AND  = 4'd2;
  localparam logic [3:0] SUB_OR   = 4'd3;
  localparam logic [3:0] SUB_INC  = 4'd4;
  localparam logic [3:0] SUB_DEC  = 4'd5;
  localparam logic [3:0] SUB_INV  = 4'd6;
  localparam logic [3:0] SUB_XOR  = 4'd7;
  localparam logic [3:0] SUB_PUSH = 4'd12;
  localparam logic [3:0] SUB_POP  = 4'd13;
  localparam logic [3:0] SUB_XCHG = 4'd15;

  // Output event kinds
  localparam logic [1:0] IO_NONE = 2'd0;
  localparam logic [1:0] IO_NUM  = 2'd1;
  localparam logic [1:0] IO_CHR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_OP1,
    ST_OP2,
    ST_OP3,
    ST_DONE
  } avm_state_e;

  // One memory access per cycle; rnd_en marks a read that sees the random port
  typedef struct packed {
    logic              re;
    logic              we;
    logic              rnd_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } avm_mem_req_t;

endpackage

`default_nettype wire

[src/avm_in_if.sv]
// Input channel of the accumulator machine core.
`default_nettype none

interface avm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  load_addr;
  logic [15:0] load_data;
  logic [15:0] random_value;

  modport source (output valid, op, load_addr, load_data, random_value, input ready);
  modport sink   (input valid, op, load_addr, load_data, random_value, output ready);
endinterface

`default_nettype wire

[src/avm_out_if.sv]
// Result channel of the accumulator machine core.
`default_nettype none

interface avm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         io_kind;
  logic signed [15:0] io_value;
  logic [15:0]        next_ip;
  logic signed [15:0] accumulator;
  logic               stopped;
  logic               bad_instruction;

  modport source (output valid, io_kind, io_value, next_ip, accumulator, stopped,
                  bad_instruction, input ready);
  modport sink   (input valid, io_kind, io_value, next_ip, accumulator, stopped,
                  bad_instruction, output ready);
endinterface

`default_nettype wire

[src/accumulator_vm_core.sv]
// Accumulator machine core: sequencer around one single-port 256x16 memory.
// A load item, or an execute while halted, goes from IDLE to DONE and then into the result
// register; an execute item first passes FETCH and up to three dependent memory steps.
// One item in flight: the next transfer is taken once the sequencer is back in IDLE,
// after the result registers; a result held by the receiver stalls the sequencer.
// Reset: async, active low; IP 16, acc 0, flags clear; unwritten words read 0 (SP 0xDF).
`default_nettype none

`include "accumulator_vm_core_assert.svh"

module accumulator_vm_core import avm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  avm_in_if.sink         in_i,
  avm_out_if.source      out_o
);

  // Sequencer state
  avm_state_e        state_q, state_d;
  logic [DATA_W-1:0] ip_q, ip_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              halted_q, halted_d;
  logic              invalid_q, invalid_d;

  // Per-item working registers
  logic [DATA_W-1:0] w_q, w_d;       // instruction word
  logic [DATA_W-1:0] tmp_q, tmp_d;   // push value or updated stack pointer
  logic [DATA_W-1:0] rnd_q, rnd_d;
  logic [1:0]        io_kind_q, io_kind_d;
  logic [DATA_W-1:0] io_val_q, io_val_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_kind_q;
  logic [DATA_W-1:0] out_val_q;
  logic [DATA_W-1:0] out_ip_q;
  logic [DATA_W-1:0] out_acc_q;
  logic              out_stop_q;
  logic              out_bad_q;
  logic              out_load;

  // Memory interface
  avm_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;

  // Store through mem_wr semantics: ports turn into output events
  logic              port_wr_en;
  logic [ADDR_W-1:0] port_wr_addr;
  logic [DATA_W-1:0] port_wr_val;

  // Decode fields; in FETCH the word comes straight from the memory
  logic [DATA_W-1:0] inst;
  logic [7:0]        pfx;
  logic [7:0]        opnd;
  logic [3:0]        sub;
  logic [3:0]        rsel;

  assign inst = (state_q == ST_FETCH) ? mem_rdata : w_q;
  assign pfx  = inst[15:8];
  assign opnd = inst[7:0];
  assign sub  = inst[7:4];
  assign rsel = inst[3:0];

  avm_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rnd_i   (rnd_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    ip_d         = ip_q;
    acc_d        = acc_q;
    halted_d     = halted_q;
    invalid_d    = invalid_q;
    w_d          = w_q;
    tmp_d        = tmp_q;
    rnd_d        = rnd_q;
    io_kind_d    = io_kind_q;
    io_val_d     = io_val_q;
    mem_req      = '0;
    port_wr_en   = 1'b0;
    port_wr_addr = '0;
    port_wr_val  = '0;
    out_load     = 1'b0;
    in_i.ready   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          rnd_d     = in_i.random_value;
          io_kind_d = IO_NONE;
          io_val_d  = '0;
          if (!in_i.op) begin
            // direct load: raw write, ports included
            mem_req.we    = 1'b1;
            mem_req.addr  = in_i.load_addr;
            mem_req.wdata = in_i.load_data;
            state_d       = ST_DONE;
          end else if (halted_q) begin
            state_d = ST_DONE;
          end else if (ip_q[15:8] != '0) begin
            halted_d = 1'b1;
            state_d  = ST_DONE;
          end else begin
            mem_req.re   = 1'b1;
            mem_req.addr = ip_q[7:0];
            state_d      = ST_FETCH;
          end
        end
      end

      ST_FETCH: begin
        w_d     = mem_rdata;
        ip_d    = ip_q + 16'd1;
        state_d = ST_DONE;
        unique case (pfx)
          PFX_HALT: ip_d = HALT_IP;
          PFX_LD, PFX_LDI, PFX_STI: begin
            mem_req.re     = 1'b1;
            mem_req.rnd_en = 1'b1;
            mem_req.addr   = opnd;
            state_d        = ST_OP1;
          end
          PFX_ST: begin
            port_wr_en   = 1'b1;
            port_wr_addr = opnd;
            port_wr_val  = acc_q;
          end
          PFX_JZ: begin
            if (acc_q == '0) begin
              ip_d = {8'h00, opnd};
            end
          end
          PFX_JN: begin
            if (acc_q[15]) begin
              ip_d = {8'h00, opnd};
            end
          end
          PFX_JAL: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = REG_LINK;
            mem_req.wdata = ip_q + 16'd1;
            ip_d          = {8'h00, opnd};
          end
          PFX_JI: begin
            mem_req.re   = 1'b1;
            mem_req.addr = opnd;
            state_d      = ST_OP1;
          end
          PFX_ALU: begin
            mem_req.re   = 1'b1;
            mem_req.addr = (sub == SUB_POP) ? REG_STACK : {4'h0, rsel};
            state_d      = ST_OP1;
          end
          PFX_SET: acc_d = {8'h00, opnd};
          default: begin
            halted_d  = 1'b1;
            invalid_d = 1'b1;
          end
        endcase
      end

      ST_OP1: begin
        state_d = ST_DONE;
        unique case (pfx)
          PFX_LD: acc_d = mem_rdata;
          PFX_LDI: begin
            mem_req.re     = 1'b1;
            mem_req.rnd_en = 1'b1;
            mem_req.addr   = mem_rdata[7:0];
            state_d        = ST_OP2;
          end
          PFX_STI: begin
            port_wr_en   = 1'b1;
            port_wr_addr = mem_rdata[7:0];
            port_wr_val  = acc_q;
          end
          PFX_JI: ip_d = mem_rdata;
          PFX_ALU: begin
            unique case (sub)
              SUB_ADD: acc_d = acc_q + mem_rdata;
              SUB_SUB: acc_d = acc_q - mem_rdata;
              SUB_AND: acc_d = acc_q & mem_rdata;
              SUB_OR:  acc_d = acc_q | mem_rdata;
              SUB_XOR: acc_d = acc_q ^ mem_rdata;
              SUB_INC: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = {4'h0, rsel};
                mem_req.wdata = mem_rdata + 16'd1;
              end
              SUB_DEC: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = {4'h0, rsel};
                mem_req.wdata = mem_rdata - 16'd1;
              end
              SUB_INV: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = {4'h0, rsel};
                mem_req.wdata = ~mem_rdata;
              end
              SUB_XCHG: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = {4'h0, rsel};
                mem_req.wdata = acc_q;
                acc_d         = mem_rdata;
              end
              SUB_PUSH: begin
                tmp_d        = mem_rdata;
                mem_req.re   = 1'b1;
                mem_req.addr = REG_STACK;
                state_d      = ST_OP2;
              end
              SUB_POP: begin
                // pre-increment the stack pointer
                tmp_d         = mem_rdata + 16'd1;
                mem_req.we    = 1'b1;
                mem_req.addr  = REG_STACK;
                mem_req.wdata = mem_rdata + 16'd1;
                state_d       = ST_OP2;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      ST_OP2: begin
        state_d = ST_DONE;
        if (pfx == PFX_LDI) begin
          acc_d = mem_rdata;
        end else if (pfx == PFX_ALU && sub == SUB_PUSH) begin
          // push lands on the stack word itself: decrement the pushed value
          port_wr_en   = 1'b1;
          port_wr_addr = mem_rdata[7:0];
          port_wr_val  = tmp_q;
          tmp_d        = (mem_rdata[7:0] == REG_STACK) ? tmp_q - 16'd1
                                                       : mem_rdata - 16'd1;
          state_d      = ST_OP3;
        end else if (pfx == PFX_ALU && sub == SUB_POP) begin
          mem_req.re     = 1'b1;
          mem_req.rnd_en = 1'b1;
          mem_req.addr   = tmp_q[7:0];
          state_d        = ST_OP3;
        end
      end

      ST_OP3: begin
        state_d     = ST_DONE;
        mem_req.we  = 1'b1;
        if (sub == SUB_PUSH) begin
          mem_req.addr  = REG_STACK;
          mem_req.wdata = tmp_q;
        end else begin
          mem_req.addr  = {4'h0, rsel};
          mem_req.wdata = mem_rdata;
        end
      end

      ST_DONE: begin
        // hand over to the result register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // Store path: ports emit an event, other addresses write memory
    if (port_wr_en) begin
      priority if (port_wr_addr == PORT_NUM) begin
        io_kind_d = IO_NUM;
        io_val_d  = port_wr_val;
      end else if (port_wr_addr == PORT_CHR) begin
        io_kind_d = IO_CHR;
        io_val_d  = port_wr_val;
      end else begin
        mem_req.we    = 1'b1;
        mem_req.addr  = port_wr_addr;
        mem_req.wdata = port_wr_val;
      end
    end

    // Instruction end: a pointer past the memory halts the machine
    if (state_q != ST_IDLE && state_q != ST_DONE && state_d == ST_DONE) begin
      if (ip_d[15:8] != '0) begin
        halted_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ip_q        <= PROGRAM_BASE;
      acc_q       <= '0;
      halted_q    <= 1'b0;
      invalid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ip_q        <= ip_d;
      acc_q       <= acc_d;
      halted_q    <= halted_d;
      invalid_q   <= invalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    tmp_q     <= tmp_d;
    rnd_q     <= rnd_d;
    io_kind_q <= io_kind_d;
    io_val_q  <= io_val_d;
    if (out_load) begin
      out_kind_q <= io_kind_q;
      out_val_q  <= io_val_q;
      out_ip_q   <= ip_q;
      out_acc_q  <= acc_q;
      out_stop_q <= halted_q;
      out_bad_q  <= invalid_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.io_kind         = out_kind_q;
  assign out_o.io_value        = $signed(out_val_q);
  assign out_o.next_ip         = out_ip_q;
  assign out_o.accumulator     = $signed(out_acc_q);
  assign out_o.stopped         = out_stop_q;
  assign out_o.bad_instruction = out_bad_q;

  `AVM_ASSERT(a_mem_one_access, clk_i, rst_ni, !(mem_req.re && mem_req.we), "memory read and write in one cycle")
  `AVM_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q, "halt flag cleared")
  `AVM_ASSERT(a_bad_implies_stop, clk_i, rst_ni, !out_valid_q || !out_bad_q || out_stop_q, "bad instruction without halt")
  `AVM_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni, state_q == ST_DONE && (!out_valid_q || out_o.ready), out_valid_q && state_q == ST_IDLE, "result not registered")

endmodule

`default_nettype wire

[src/avm_mem.sv]
// Single-port 256x16 main memory with per-word valid bits and random port read.
`default_nettype none

module avm_mem import avm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avm_mem_req_t        req_i,
  input  logic [DATA_W-1:0]   rnd_i,
  output logic [DATA_W-1:0]   rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] rdflt_q;
  logic              rvld_q;
  logic              rsel_q;

  // Storage and read data, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
      rdflt_q <= (req_i.addr == REG_STACK) ? SP_RESET : '0;
    end
  end

  // Unwritten words read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      rsel_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.addr];
        rsel_q <= req_i.rnd_en && (req_i.addr == PORT_RND);
      end
    end
  end

  assign rdata_o = rsel_q ? rnd_i : (rvld_q ? rdata_q : rdflt_q);

endmodule

`default_nettype wire

[bench/accumulator_vm_core_tb.sv]
// Self-checking testbench for the accumulator machine core.
`timescale 1ns / 100ps

module accumulator_vm_core_tb import avm_pkg::*; ();

  // Item kinds on the input channel
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EXEC = 1'b1;

  // First address past memory; any pointer at or above it stops the machine
  localparam logic [15:0] MEM_END = 16'h0100;
  // An ALU subop with no effect
  localparam logic [3:0] SUB_NOP = 4'd9;

  // Result of one step as the block should report it
  typedef struct packed {
    logic [1:0]  io_kind;
    logic [15:0] io_value;
    logic [15:0] next_ip;
    logic [15:0] accumulator;
    logic        stopped;
    logic        bad_instruction;
  } step_result_t;

  logic clk_i;
  logic rst_ni;

  avm_in_if  in_if ();
  avm_out_if out_if ();

  accumulator_vm_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Machine state as the bench sees it
  logic [15:0] mach_mem [0:255];
  logic [15:0] mach_ip;
  logic [15:0] mach_acc;
  logic        mach_halted;
  logic        mach_bad;

  // Per-step scratch: port event and the random word of the current item
  logic [1:0]  step_io_kind;
  logic [15:0] step_io_value;
  logic [15:0] step_rnd;

  step_result_t pending_steps [$];

  int n_fail;
  int items_sent;
  bit idle_on;
  bit long_hold_req;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Machine model
  // ---------------------------------------------------------------------------

  // Data read: only the random port is special
  function automatic logic [15:0] mach_read(input logic [15:0] addr);
    if (addr[7:0] == PORT_RND) return step_rnd;
    return mach_mem[addr[7:0]];
  endfunction

  // Data write: the two output ports raise an event and leave memory alone
  function automatic void mach_write(input logic [15:0] addr, input logic [15:0] val);
    if (addr[7:0] == PORT_NUM) begin
      step_io_kind  = IO_NUM;
      step_io_value = val;
    end else if (addr[7:0] == PORT_CHR) begin
      step_io_kind  = IO_CHR;
      step_io_value = val;
    end else begin
      mach_mem[addr[7:0]] = val;
    end
  endfunction

  // ALU prefix: subop in [7:4], register in [3:0]; registers are read raw
  function automatic void mach_alu(input logic [15:0] word);
    logic [7:0]  r;
    logic [15:0] tmp;
    r = {4'h0, word[3:0]};
    case (word[7:4])
      SUB_ADD: mach_acc = mach_acc + mach_mem[r];
      SUB_SUB: mach_acc = mach_acc - mach_mem[r];
      SUB_AND: mach_acc = mach_acc & mach_mem[r];
      SUB_OR:  mach_acc = mach_acc | mach_mem[r];
      SUB_INC: mach_mem[r] = mach_mem[r] + 16'd1;
      SUB_DEC: mach_mem[r] = mach_mem[r] - 16'd1;
      SUB_INV: mach_mem[r] = ~mach_mem[r];
      SUB_XOR: mach_acc = mach_acc ^ mach_mem[r];
      SUB_PUSH: begin
        // write first, then move the stack pointer (it may be the target)
        mach_write(mach_mem[REG_STACK], mach_mem[r]);
        mach_mem[REG_STACK] = mach_mem[REG_STACK] - 16'd1;
      end
      SUB_POP: begin
        mach_mem[REG_STACK] = mach_mem[REG_STACK] + 16'd1;
        mach_mem[r] = mach_read(mach_mem[REG_STACK]);
      end
      SUB_XCHG: begin
        tmp = mach_mem[r];
        mach_mem[r] = mach_acc;
        mach_acc = tmp;
      end
      default: ;
    endcase
  endfunction

  function automatic void mach_execute();
    logic [15:0] word;
    logic [7:0]  b;
    if (mach_ip >= MEM_END) begin
      mach_halted = 1'b1;
      return;
    end
    word    = mach_mem[mach_ip[7:0]];
    mach_ip = mach_ip + 16'd1;
    b       = word[7:0];
    case (word[15:8])
      PFX_HALT: mach_ip = HALT_IP;
      PFX_LD:   mach_acc = mach_read({8'h00, b});
      PFX_ST:   mach_write({8'h00, b}, mach_acc);
      PFX_LDI:  mach_acc = mach_read(mach_read({8'h00, b}));
      PFX_STI:  mach_write(mach_read({8'h00, b}), mach_acc);
      PFX_JZ:   if (mach_acc == 16'h0000) mach_ip = {8'h00, b};
      PFX_JN:   if (mach_acc[15]) mach_ip = {8'h00, b};
      PFX_JAL: begin
        mach_mem[REG_LINK] = mach_ip;
        mach_ip = {8'h00, b};
      end
      PFX_JI:   mach_ip = mach_mem[b];
      PFX_ALU:  mach_alu(word);
      PFX_SET:  mach_acc = {8'h00, b};
      default: begin
        // pointer stays past the bad word
        mach_halted = 1'b1;
        mach_bad    = 1'b1;
        return;
      end
    endcase
    if (mach_ip >= MEM_END) mach_halted = 1'b1;
  endfunction

  // Apply one accepted item to the model and queue the result it must produce
  function automatic void advance_machine(input logic op, input logic [7:0] addr,
                                          input logic [15:0] data, input logic [15:0] rnd);
    step_result_t res;
    step_io_kind  = IO_NONE;
    step_io_value = 16'h0000;
    step_rnd      = rnd;
    if (op == OP_LOAD) mach_mem[addr] = data;
    else if (!mach_halted) mach_execute();
    res.io_kind         = step_io_kind;
    res.io_value        = step_io_value;
    res.next_ip         = mach_ip;
    res.accumulator     = mach_acc;
    res.stopped         = mach_halted;
    res.bad_instruction = mach_bad;
    pending_steps.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Would this word, placed at the current pointer, keep the machine running?
  function automatic bit keeps_running(input logic [15:0] word);
    logic [15:0] nip;
    nip = mach_ip + 16'd1;
    case (word[15:8])
      PFX_JZ:  if (mach_acc == 16'h0000) nip = {8'h00, word[7:0]};
      PFX_JN:  if (mach_acc[15]) nip = {8'h00, word[7:0]};
      PFX_JAL: nip = {8'h00, word[7:0]};
      // jumping through its own slot reads the word itself
      PFX_JI:  nip = (word[7:0] == mach_ip[7:0]) ? word : mach_mem[word[7:0]];
      PFX_LD, PFX_ST, PFX_LDI, PFX_STI, PFX_ALU, PFX_SET: ;
      default: return 1'b0;
    endcase
    return nip < MEM_END;
  endfunction

  // Addresses biased toward registers and the port / stack window
  function automatic logic [7:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 15));
      1:       return 8'($urandom_range(PORT_NUM - 2, PORT_RND + 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_data();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 255));
      1:       return 16'($urandom_range(16'h00DC, 16'h00E4));
      2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // A legal instruction; ALU words are weighted up since they carry most subops
  function automatic logic [15:0] rand_instr();
    logic [7:0] pfx;
    logic [7:0] b;
    case ($urandom_range(0, 13))
      0:       pfx = PFX_LD;
      1:       pfx = PFX_ST;
      2:       pfx = PFX_LDI;
      3:       pfx = PFX_STI;
      4:       pfx = PFX_JZ;
      5:       pfx = PFX_JN;
      6:       pfx = PFX_JAL;
      7:       pfx = PFX_JI;
      8:       pfx = PFX_SET;
      default: pfx = PFX_ALU;
    endcase
    b = (pfx == PFX_ALU) ? 8'($urandom) : pick_addr();
    return {pfx, b};
  endfunction

  // One transfer on the input channel; valid stays up for back-to-back items
  task automatic send_item(input logic op, input logic [7:0] addr,
                           input logic [15:0] data, input logic [15:0] rnd);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.load_addr    <= addr;
    in_if.load_data    <= data;
    in_if.random_value <= rnd;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    advance_machine(op, addr, data, rnd);
    items_sent++;
  endtask

  task automatic exec_once(input logic [15:0] rnd);
    send_item(OP_EXEC, 8'($urandom), 16'($urandom), rnd);
  endtask

  // Place a word at the pointer and run it
  task automatic run_instr(input logic [15:0] word, input logic [15:0] rnd);
    send_item(OP_LOAD, mach_ip[7:0], word, 16'($urandom));
    exec_once(rnd);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operands for the directed program; a load to a port word gives no event
  task automatic test_loads();
    send_item(OP_LOAD, 8'h00, 16'hFFFF, 16'h0000);
    send_item(OP_LOAD, 8'h01, 16'hFFE1, 16'hFFFF);   // pointer to char port, high byte cut
    send_item(OP_LOAD, 8'h02, 16'h12E2, 16'h0000);   // pointer to random port, high byte cut
    send_item(OP_LOAD, PORT_NUM, 16'h0000, 16'hFFFF);
  endtask

  // Every prefix but HALT once, with both outcomes of JZ
  task automatic test_instructions();
    run_instr({PFX_SET, 8'hFF}, 16'h0000);
    run_instr({PFX_LD, PORT_RND}, 16'hFFFF);         // acc = -1
    run_instr({PFX_JN, 8'h30}, 16'h0000);            // taken
    run_instr({PFX_JZ, 8'h60}, 16'h0000);            // not taken
    run_instr({PFX_ST, PORT_NUM}, 16'h0000);         // decimal event
    run_instr({PFX_LDI, 8'h02}, 16'h0000);           // acc = random word = 0
    run_instr({PFX_JZ, 8'h80}, 16'hFFFF);            // taken
    run_instr({PFX_STI, 8'h01}, 16'h0000);           // char event
    run_instr({PFX_JAL, 8'h40}, 16'h0000);
    run_instr({PFX_JI, REG_LINK}, 16'h0000);         // back to the link
    run_instr({PFX_ALU, SUB_ADD, 4'h0}, 16'h0000);
    run_instr({PFX_ALU, SUB_NOP, 4'h0}, 16'h0000);
  endtask

  // Random programs built just ahead of the pointer, plus stray loads that
  // disturb registers, the stack pointer, ports and code
  task automatic test_random_program(input int n_items);
    int          target;
    logic [15:0] word;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 3) == 0)
          send_item(OP_LOAD, REG_STACK, 16'($urandom_range(16'h00DC, 16'h00E4)),
                    16'($urandom));
        else
          send_item(OP_LOAD, pick_addr(), pick_data(), 16'($urandom));
      end else begin
        // reuse what is there now and then, so stores into code get executed
        if (!keeps_running(mach_mem[mach_ip[7:0]]) || $urandom_range(0, 2) != 0) begin
          do word = rand_instr(); while (!keeps_running(word));
          send_item(OP_LOAD, mach_ip[7:0], word, 16'($urandom));
        end
        exec_once(pick_data());
      end
    end
  endtask

  // Receiver stops for a long stretch while items keep coming
  task automatic test_output_stall();
    long_hold_req = 1'b1;
    test_random_program(60);
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_sender_pause();
    test_random_program(30);
    drain_results();
    test_random_program(30);
  endtask

  // Only one stop is possible per run; the seed picks which kind
  task automatic test_halt();
    logic [7:0] b;
    int         v;
    b = 8'($urandom);
    case ($urandom_range(0, 3))
      0: run_instr({PFX_HALT, b}, 16'($urandom));
      1: begin
        // prefixes 1..3 and 14..255 are undefined
        v = $urandom_range(0, 244);
        run_instr({(v < 3) ? 8'(v + 1) : 8'(v + 11), b}, 16'($urandom));
      end
      2: begin
        send_item(OP_LOAD, 8'h03, 16'h8000 | 16'($urandom), 16'($urandom));
        run_instr({PFX_JI, 8'h03}, 16'($urandom));
      end
      default: begin
        // last word of memory runs, then the pointer walks off the end
        run_instr({PFX_JAL, 8'hFF}, 16'($urandom));
        run_instr({PFX_SET, b}, 16'($urandom));
      end
    endcase
    // halted: executes report the frozen state, loads still land
    repeat (2) exec_once(16'($urandom));
    send_item(OP_LOAD, PROGRAM_BASE[7:0], {PFX_SET, b}, 16'($urandom));
    send_item(OP_LOAD, pick_addr(), pick_data(), 16'($urandom));
    exec_once(16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold on request, in-order compare
  // ---------------------------------------------------------------------------

  task automatic check_result();
    step_result_t exp_r;
    if (pending_steps.size() == 0) begin
      $error("result transfer with no step outstanding");
      n_fail++;
      return;
    end
    exp_r = pending_steps.pop_front();
    if (out_if.io_kind !== exp_r.io_kind) begin
      $error("io_kind: expected %0d, got %0d", exp_r.io_kind, out_if.io_kind);
      n_fail++;
    end
    if (out_if.io_value !== exp_r.io_value) begin
      $error("io_value: expected %0d, got %0d", $signed(exp_r.io_value), out_if.io_value);
      n_fail++;
    end
    if (out_if.next_ip !== exp_r.next_ip) begin
      $error("next_ip: expected %0d, got %0d", exp_r.next_ip, out_if.next_ip);
      n_fail++;
    end
    if (out_if.accumulator !== exp_r.accumulator) begin
      $error("accumulator: expected %0d, got %0d", $signed(exp_r.accumulator),
             out_if.accumulator);
      n_fail++;
    end
    if (out_if.stopped !== exp_r.stopped) begin
      $error("stopped: expected %0d, got %0d", exp_r.stopped, out_if.stopped);
      n_fail++;
    end
    if (out_if.bad_instruction !== exp_r.bad_instruction) begin
      $error("bad_instruction: expected %0d, got %0d", exp_r.bad_instruction,
             out_if.bad_instruction);
      n_fail++;
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        // long enough for the block to back up into its input
        long_hold_req = 1'b0;
        hold_left = 80;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.op           <= OP_LOAD;
    in_if.load_addr    <= 8'h00;
    in_if.load_data    <= 16'h0000;
    in_if.random_value <= 16'h0000;
    n_fail        = 0;
    items_sent    = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;

    // model reset state
    foreach (mach_mem[i]) mach_mem[i] = 16'h0000;
    mach_mem[REG_STACK] = SP_RESET;
    mach_ip     = PROGRAM_BASE;
    mach_acc    = 16'h0000;
    mach_halted = 1'b0;
    mach_bad    = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_loads();
    test_instructions();
    test_random_program(900);
    test_output_stall();
    test_sender_pause();
    test_random_program(500);
    // closing stretch runs at full rate on both sides
    idle_on = 1'b0;
    test_random_program(300);
    test_halt();

    drain_results();
    // an extra result would show up during this wait
    repeat (30) @(posedge clk_i);
    if (n_fail == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/avm_pkg.sv
src/avm_in_if.sv
src/avm_out_if.sv
src/avm_mem.sv
src/accumulator_vm_core.sv
bench/accumulator_vm_core_tb.sv
